FILE: rtl/cws_pkg.sv
// Shared types and constants for the congestion window sender.
package cws_pkg;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_FIN_ACK = 2'd3
  } cws_action_e;

  // configuration register indexes
  localparam logic [1:0] REG_TOTAL_SEGMENTS    = 2'd0;
  localparam logic [1:0] REG_INITIAL_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS     = 2'd2;

  localparam logic [15:0] RST_TOTAL_SEGMENTS = 16'd1;
  localparam logic [10:0] RST_THRESHOLD      = 11'd16;
  localparam logic [23:0] RST_TIMEOUT_TICKS  = 24'd1000000;

  // largest window the 11-bit field can carry
  localparam int unsigned WINDOW_FIELD_MAX = 2047;

  typedef struct packed {
    logic [15:0] total_segments;
    logic [23:0] timeout_ticks;
    logic        thr_load;
    logic [10:0] thr_value;
  } cws_cfg_t;

  typedef struct packed {
    logic        send_valid;
    logic [16:0] send_seq;
    logic        send_is_resend;
    logic        send_is_fin;
    logic        timed_out;
    logic [10:0] window_size;
    logic [10:0] slow_start_threshold;
    logic [15:0] acked_base;
    logic        transfer_done;
  } cws_result_t;

endpackage

FILE: rtl/cws_cfg.sv
// Configuration registers of the congestion window sender.
module cws_cfg import cws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output cws_cfg_t    cfg_o
);

  logic [15:0] total_q, total_d;
  logic [23:0] timeout_q, timeout_d;
  logic        thr_load;
  logic [10:0] thr_value;

  always_comb begin
    total_d   = total_q;
    timeout_d = timeout_q;
    thr_load  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TOTAL_SEGMENTS:    total_d   = cfg_data_i[15:0];
        REG_INITIAL_THRESHOLD: thr_load  = 1'b1;
        REG_TIMEOUT_TICKS:     timeout_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero threshold behaves as one
  assign thr_value = (cfg_data_i[10:0] == 11'd0) ? 11'd1 : cfg_data_i[10:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= RST_TOTAL_SEGMENTS;
      timeout_q <= RST_TIMEOUT_TICKS;
    end else begin
      total_q   <= total_d;
      timeout_q <= timeout_d;
    end
  end

  assign cfg_o.total_segments = total_q;
  assign cfg_o.timeout_ticks  = timeout_q;
  assign cfg_o.thr_load       = thr_load;
  assign cfg_o.thr_value      = thr_value;

endmodule

FILE: rtl/cws_engine.sv
// Window state registers and the per-event update logic.
module cws_engine import cws_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cws_cfg_t    cfg_i,
  input  logic        step_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] ack_number_i,
  output cws_result_t result_o
);

  localparam int unsigned WinCapInt =
    (MAX_WINDOW < WINDOW_FIELD_MAX) ? MAX_WINDOW : WINDOW_FIELD_MAX;
  localparam logic [11:0] WinCap = 12'(WinCapInt);

  logic [10:0] window_q, window_d;
  logic [10:0] thr_q, thr_d;
  logic [15:0] base_q, base_d;
  logic [10:0] sent_q, sent_d;
  logic [10:0] acks_q, acks_d;
  logic        resend_q, resend_d;
  logic [16:0] goal_q, goal_d;
  logic [16:0] last_q, last_d;
  logic [23:0] timer_q, timer_d;
  logic        done_q, done_d;

  cws_action_e act;
  logic        data_phase;
  logic [16:0] next_off;
  logic [16:0] next_seq;
  logic [11:0] acks_inc;
  logic [11:0] grown;
  logic [23:0] timer_inc;
  logic [9:0]  half_win;
  logic        sv, rs, fin, to;
  logic [16:0] seq;

  assign act        = cws_action_e'(action_i);
  assign data_phase = base_q < cfg_i.total_segments;
  assign next_off   = {1'b0, base_q} + {6'd0, sent_q};
  assign next_seq   = next_off + 17'd1;
  assign acks_inc   = {1'b0, acks_q} + 12'd1;
  assign grown      = (window_q < thr_q) ? {window_q, 1'b0} : ({1'b0, window_q} + 12'd1);
  assign timer_inc  = timer_q + 24'd1;
  assign half_win   = window_q[10:1];

  always_comb begin
    window_d = window_q;
    thr_d    = thr_q;
    base_d   = base_q;
    sent_d   = sent_q;
    acks_d   = acks_q;
    resend_d = resend_q;
    goal_d   = goal_q;
    last_d   = last_q;
    timer_d  = timer_q;
    done_d   = done_q;
    sv = 1'b0; rs = 1'b0; fin = 1'b0; to = 1'b0;
    seq = 17'd0;
    if (!done_q) begin
      case (act)
        ACT_SEND: begin
          if (!data_phase) begin
            sv  = 1'b1;
            fin = 1'b1;
            seq = last_q + 17'd1;
          end else if (sent_q < window_q &&
                       next_off < {1'b0, cfg_i.total_segments}) begin
            sv     = 1'b1;
            seq    = next_seq;
            rs     = resend_q;
            last_d = next_seq;
            if (resend_q && next_seq == goal_q) resend_d = 1'b0;
            if (next_seq == {1'b0, cfg_i.total_segments}) begin
              sent_d   = window_q;
              resend_d = 1'b0;
            end else begin
              sent_d = sent_q + 11'd1;
            end
          end
        end
        ACT_ACK: begin
          if (ack_number_i > base_q) begin
            base_d = ack_number_i;
            acks_d = acks_inc[10:0];
            if (acks_inc >= {1'b0, window_q}) begin
              window_d = (grown > WinCap) ? WinCap[10:0] : grown[10:0];
              sent_d   = 11'd0;
              acks_d   = 11'd0;
              timer_d  = 24'd0;
            end
          end
        end
        ACT_TICK: begin
          if (data_phase && sent_q >= window_q) begin
            timer_d = timer_inc;
            if (timer_inc >= cfg_i.timeout_ticks || timer_inc == 24'd0) begin
              thr_d = (half_win == 10'd0) ? 11'd1 : {1'b0, half_win};
              if (!resend_q) goal_d = last_q;
              last_d   = {1'b0, base_q};
              resend_d = 1'b1;
              sent_d   = 11'd0;
              window_d = 11'd1;
              acks_d   = 11'd0;
              timer_d  = 24'd0;
              to       = 1'b1;
            end
          end
        end
        ACT_FIN_ACK: begin
          if (!data_phase) done_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 11'd1;
      thr_q    <= RST_THRESHOLD;
      base_q   <= 16'd0;
      sent_q   <= 11'd0;
      acks_q   <= 11'd0;
      resend_q <= 1'b0;
      goal_q   <= 17'd0;
      last_q   <= 17'd0;
      timer_q  <= 24'd0;
      done_q   <= 1'b0;
    end else if (cfg_i.thr_load) begin
      thr_q <= cfg_i.thr_value;
    end else if (step_i) begin
      window_q <= window_d;
      thr_q    <= thr_d;
      base_q   <= base_d;
      sent_q   <= sent_d;
      acks_q   <= acks_d;
      resend_q <= resend_d;
      goal_q   <= goal_d;
      last_q   <= last_d;
      timer_q  <= timer_d;
      done_q   <= done_d;
    end
  end

  assign result_o.send_valid           = sv;
  assign result_o.send_seq             = seq;
  assign result_o.send_is_resend       = rs;
  assign result_o.send_is_fin          = fin;
  assign result_o.timed_out            = to;
  assign result_o.window_size          = window_d;
  assign result_o.slow_start_threshold = thr_d;
  assign result_o.acked_base           = base_d;
  assign result_o.transfer_done        = done_d;

endmodule

FILE: rtl/congestion_window_sender.sv
// Top level of the go-back-N congestion window sender.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per transaction:
//   action_i selects send request, ack, timer tick or fin-ack; ack_number_i
//   is the cumulative ack of an arriving ack.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per event: the segment to send (if any), the timeout flag and
//   the window, threshold, acked base and done flag after the event.
//   Path: an accepted transaction passes the input register, then the update
//   logic, then the result register.
//   Throughput: one event per cycle while the result side is not stalled; the
//   state update is a single pass of compares and adds, so back-to-back events chain through the state regs.
//   Stall: while the result register is full and stalled, the input register
//   holds its event and in_stall_o rises once it is occupied too.
//   Reset: window 1, threshold 16, base 0, segments 1, timeout 1000000 ticks.
//   Config writes (cfg_we_i) are made with no events in flight; a threshold
//   write also reloads the live threshold.
module congestion_window_sender import cws_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] ack_number_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic [16:0] send_seq_o,
  output logic        send_is_resend_o,
  output logic        send_is_fin_o,
  output logic        timed_out_o,
  output logic [10:0] window_size_o,
  output logic [10:0] slow_start_threshold_o,
  output logic [15:0] acked_base_o,
  output logic        transfer_done_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned WinCapInt =
    (MAX_WINDOW < WINDOW_FIELD_MAX) ? MAX_WINDOW : WINDOW_FIELD_MAX;
  localparam logic [10:0] WinCap = 11'(WinCapInt);

  cws_cfg_t    cfg;
  cws_result_t result;

  // input register stage
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_action_q;
  logic [15:0] s1_ack_q;

  // result register stage
  logic        out_valid_q, out_valid_d;
  cws_result_t out_q;

  logic out_ready;   // result register can take a transaction this cycle
  logic advance;     // event in the input register is processed now
  logic accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)       s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)        out_valid_d = 1'b1;
    else if (out_ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_i;
      s1_ack_q    <= ack_number_i;
    end
    if (advance) out_q <= result;
  end

  cws_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cws_engine #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (advance),
    .action_i     (s1_action_q),
    .ack_number_i (s1_ack_q),
    .result_o     (result)
  );

  assign out_valid_o            = out_valid_q;
  assign send_valid_o           = out_q.send_valid;
  assign send_seq_o             = out_q.send_seq;
  assign send_is_resend_o       = out_q.send_is_resend;
  assign send_is_fin_o          = out_q.send_is_fin;
  assign timed_out_o            = out_q.timed_out;
  assign window_size_o          = out_q.window_size;
  assign slow_start_threshold_o = out_q.slow_start_threshold;
  assign acked_base_o           = out_q.acked_base;
  assign transfer_done_o        = out_q.transfer_done;

`ifndef ASSERT_OFF
  // input only backs up when the result register is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // no segment means no sequence number or segment flags
  a_idle_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !send_valid_o) |->
      (send_seq_o == 17'd0 && !send_is_resend_o && !send_is_fin_o))
    else $error("segment fields set without a send");

  // a timeout collapses the window and sends nothing
  a_timeout_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |-> (window_size_o == 11'd1 && !send_valid_o))
    else $error("timeout did not reset the window");

  // window stays inside its cap
  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_size_o != 11'd0 && window_size_o <= WinCap))
    else $error("window out of range");
`endif

endmodule

FILE: dv/congestion_window_sender_test.sv
// Self-checking testbench for the go-back-N congestion window sender.
module congestion_window_sender_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cws_pkg::*;

  localparam int unsigned MAX_WIN        = 1024;
  localparam int unsigned WIN_CAP        = (MAX_WIN < WINDOW_FIELD_MAX) ? MAX_WIN
                                                                       : WINDOW_FIELD_MAX;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [15:0] ack_number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        send_valid_o;
  logic [16:0] send_seq_o;
  logic        send_is_resend_o;
  logic        send_is_fin_o;
  logic        timed_out_o;
  logic [10:0] window_size_o;
  logic [10:0] slow_start_threshold_o;
  logic [15:0] acked_base_o;
  logic        transfer_done_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  congestion_window_sender #(
    .MAX_WINDOW(MAX_WIN)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .action_i              (action_i),
    .ack_number_i          (ack_number_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .send_valid_o          (send_valid_o),
    .send_seq_o            (send_seq_o),
    .send_is_resend_o      (send_is_resend_o),
    .send_is_fin_o         (send_is_fin_o),
    .timed_out_o           (timed_out_o),
    .window_size_o         (window_size_o),
    .slow_start_threshold_o(slow_start_threshold_o),
    .acked_base_o          (acked_base_o),
    .transfer_done_o       (transfer_done_o),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Sender state as the testbench predicts it
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_total;
  logic [23:0] cfg_timeout;
  logic [10:0] cwnd;
  logic [10:0] ssthresh;
  logic [15:0] snd_base;
  logic [10:0] snd_count;     // segments dispatched in the current window
  logic [10:0] ack_count_w;   // acks counted in the current window
  bit          rexmit;
  logic [16:0] rexmit_goal;
  logic [16:0] snd_last;
  logic [23:0] rto_ticks;
  bit          fin_acked;

  cws_result_t predicted_outputs[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          no_gaps;
  bit          holdoff_req;

  function automatic void reset_predictor();
    cfg_total   = RST_TOTAL_SEGMENTS;
    cfg_timeout = RST_TIMEOUT_TICKS;
    cwnd        = 11'd1;
    ssthresh    = RST_THRESHOLD;
    snd_base    = '0;
    snd_count   = '0;
    ack_count_w = '0;
    rexmit      = 1'b0;
    rexmit_goal = '0;
    snd_last    = '0;
    rto_ticks   = '0;
    fin_acked   = 1'b0;
  endfunction

  // Advances the predicted state by one event and returns the result it causes.
  function automatic cws_result_t predict_sender_event(cws_action_e act, logic [15:0] ackn);
    cws_result_t r;
    int unsigned nxt;
    int unsigned grown;
    int unsigned half;
    bit          data_phase;
    r = '0;
    data_phase = (snd_base < cfg_total);
    if (!fin_acked) begin
      case (act)
        ACT_SEND: begin
          if (!data_phase) begin
            // every segment acked: the FIN goes out, again on each request
            r.send_valid  = 1'b1;
            r.send_is_fin = 1'b1;
            r.send_seq    = snd_last + 17'd1;
          end else if (snd_count < cwnd &&
                       32'(snd_base) + 32'(snd_count) < 32'(cfg_total)) begin
            nxt              = 32'(snd_base) + 32'(snd_count) + 1;
            r.send_valid     = 1'b1;
            r.send_seq       = nxt[16:0];
            r.send_is_resend = rexmit;
            snd_last         = nxt[16:0];
            if (rexmit && nxt[16:0] == rexmit_goal) rexmit = 1'b0;
            // last data segment closes the window for dispatch
            if (nxt == 32'(cfg_total)) begin
              snd_count = cwnd;
              rexmit    = 1'b0;
            end else begin
              snd_count++;
            end
          end
        end
        ACT_ACK: begin
          if (ackn > snd_base) begin
            snd_base = ackn;
            ack_count_w++;
            if (ack_count_w >= cwnd) begin
              grown       = (cwnd < ssthresh) ? 32'(cwnd) * 2 : 32'(cwnd) + 1;
              cwnd        = (grown > WIN_CAP) ? 11'(WIN_CAP) : 11'(grown);
              snd_count   = '0;
              ack_count_w = '0;
              rto_ticks   = '0;
            end
          end
        end
        ACT_TICK: begin
          if (data_phase && snd_count >= cwnd) begin
            rto_ticks = rto_ticks + 24'd1;
            // a zero timeout behaves as one tick
            if (rto_ticks >= cfg_timeout || rto_ticks == '0) begin
              half     = 32'(cwnd) / 2;
              ssthresh = (half < 1) ? 11'd1 : 11'(half);
              if (!rexmit) rexmit_goal = snd_last;
              snd_last    = 17'(snd_base);
              rexmit      = 1'b1;
              snd_count   = '0;
              cwnd        = 11'd1;
              ack_count_w = '0;
              rto_ticks   = '0;
              r.timed_out = 1'b1;
            end
          end
        end
        default: begin
          if (!data_phase) fin_acked = 1'b1;
        end
      endcase
    end
    r.window_size          = cwnd;
    r.slow_start_threshold = ssthresh;
    r.acked_base           = snd_base;
    r.transfer_done        = fin_acked;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
  endtask

  task automatic check_result();
    cws_result_t want;
    if (predicted_outputs.size() == 0) begin
      report_mismatch("result with nothing outstanding", 32'(send_seq_o), '0);
    end else begin
      want = predicted_outputs.pop_front();
      if (send_valid_o !== want.send_valid)
        report_mismatch("send_valid", 32'(send_valid_o), 32'(want.send_valid));
      if (send_seq_o !== want.send_seq)
        report_mismatch("send_seq", 32'(send_seq_o), 32'(want.send_seq));
      if (send_is_resend_o !== want.send_is_resend)
        report_mismatch("send_is_resend", 32'(send_is_resend_o), 32'(want.send_is_resend));
      if (send_is_fin_o !== want.send_is_fin)
        report_mismatch("send_is_fin", 32'(send_is_fin_o), 32'(want.send_is_fin));
      if (timed_out_o !== want.timed_out)
        report_mismatch("timed_out", 32'(timed_out_o), 32'(want.timed_out));
      if (window_size_o !== want.window_size)
        report_mismatch("window_size", 32'(window_size_o), 32'(want.window_size));
      if (slow_start_threshold_o !== want.slow_start_threshold)
        report_mismatch("slow_start_threshold", 32'(slow_start_threshold_o),
                        32'(want.slow_start_threshold));
      if (acked_base_o !== want.acked_base)
        report_mismatch("acked_base", 32'(acked_base_o), 32'(want.acked_base));
      if (transfer_done_o !== want.transfer_done)
        report_mismatch("transfer_done", 32'(transfer_done_o), 32'(want.transfer_done));
    end
  endtask

  // Outputs are read before the edge updates them; a transaction counts when
  // valid is high and the stall we drove is low.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) check_result();
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side stall: random duty in stretches, or a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_stall_gen
    int unsigned pct;
    int unsigned span;
    out_stall_i <= 1'b0;
    forever begin
      if (holdoff_req) begin
        // hold-off starts on an edge of its own
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        holdoff_req = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
        span = $urandom_range(8, 64);
        repeat (span) begin
          @(posedge clk_i);
          if (holdoff_req) break;
          out_stall_i <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One event transaction; bursts of random length with random gaps between.
  task automatic put_event(cws_action_e act, logic [15:0] ackn);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 15);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    predicted_outputs.push_back(predict_sender_event(act, ackn));
    in_valid_i   <= 1'b1;
    action_i     <= act;
    ack_number_i <= ackn;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Stop offering events and wait for every outstanding result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TOTAL_SEGMENTS:    cfg_total = value[15:0];
      REG_INITIAL_THRESHOLD: ssthresh  = (value[10:0] == '0) ? 11'd1 : value[10:0];
      REG_TIMEOUT_TICKS:     cfg_timeout = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // One event of a mostly well-formed transfer; called in the data phase only.
  task automatic send_flow_event();
    int unsigned roll;
    int unsigned hi;
    int unsigned lo;
    bit          can_send;
    roll     = $urandom_range(0, 99);
    can_send = snd_count < cwnd && 32'(snd_base) + 32'(snd_count) < 32'(cfg_total);
    // highest number a receiver could have seen, counting before a rewind
    hi = 32'(snd_last);
    if (rexmit && 32'(rexmit_goal) > hi) hi = 32'(rexmit_goal);
    lo = 32'(snd_base) + 1;
    if (roll < 50 && can_send) begin
      put_event(ACT_SEND, 16'($urandom));
    end else if (roll < 80 && hi >= lo) begin
      put_event(ACT_ACK, ($urandom_range(0, 1) == 0) ? 16'(lo) : 16'($urandom_range(lo, hi)));
    end else if (roll < 90) begin
      put_event(ACT_TICK, 16'($urandom));
    end else if (roll < 94) begin
      put_event(ACT_ACK, 16'($urandom_range(0, snd_base)));         // duplicate
    end else if (roll < 96) begin
      put_event(ACT_ACK, 16'($urandom_range(lo, cfg_total)));       // jump ahead
    end else begin
      case ($urandom_range(0, 2))
        0:       put_event(ACT_SEND, 16'($urandom));
        1:       put_event(ACT_TICK, 16'($urandom));
        default: put_event(ACT_FIN_ACK, 16'($urandom));              // ignored here
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: one segment, default timeout; fin phase reached but not closed.
  task automatic test_defaults_after_reset();
    put_event(ACT_SEND, 16'($urandom));      // seq 1, the last segment
    put_event(ACT_SEND, 16'($urandom));      // window full
    put_event(ACT_TICK, 16'($urandom));      // counts, far from timeout
    put_event(ACT_FIN_ACK, 16'($urandom));   // early fin-ack, ignored
    put_event(ACT_ACK, 16'd0);               // duplicate
    put_event(ACT_ACK, 16'd1);               // whole window acked
    put_event(ACT_SEND, 16'($urandom));      // FIN
    put_event(ACT_TICK, 16'($urandom));      // no timer in fin phase
  endtask

  // Register extremes: zero segments, zero threshold and timeout, widest values.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_TOTAL_SEGMENTS, 24'd0);
    put_event(ACT_SEND, 16'($urandom));      // FIN again
    wait_drained();
    write_reg(REG_TOTAL_SEGMENTS, 24'd65535);
    write_reg(REG_INITIAL_THRESHOLD, 24'd0);
    write_reg(REG_TIMEOUT_TICKS, 24'd0);
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_SEND, 16'($urandom));      // window full
    put_event(ACT_TICK, 16'($urandom));      // zero timeout fires on first tick
    put_event(ACT_SEND, 16'($urandom));      // retransmission
    put_event(ACT_ACK, snd_base + 16'd1);
    put_event(ACT_SEND, 16'($urandom));      // reaches the goal, leaves resend
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_ACK, 16'd1);               // duplicate
    wait_drained();
    write_reg(REG_TIMEOUT_TICKS, 24'hFF_FFFF);
    put_event(ACT_TICK, 16'($urandom));
    wait_drained();
    write_reg(REG_INITIAL_THRESHOLD, 24'd2047);
    write_reg(REG_TIMEOUT_TICKS, 24'd1);
  endtask

  // Back-to-back transfers with fresh settings each time.
  task automatic test_random_transfers();
    int unsigned issued;
    int unsigned budget;
    int unsigned size;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      wait_drained();
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 300) : $urandom_range(1, 30);
      write_reg(REG_TOTAL_SEGMENTS, 24'((32'(snd_base) + size > 65535) ? 65535
                                                                        : 32'(snd_base) + size));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_INITIAL_THRESHOLD, 24'($urandom_range(0, 2047)));
        1:       write_reg(REG_INITIAL_THRESHOLD, 24'd0);
        default: write_reg(REG_INITIAL_THRESHOLD, 24'($urandom_range(1, 32)));
      endcase
      write_reg(REG_TIMEOUT_TICKS, ($urandom_range(0, 4) == 0) ? 24'($urandom_range(1, 40))
                                                              : 24'($urandom_range(0, 6)));
      budget = 400;
      while (snd_base < cfg_total && budget > 0) begin
        send_flow_event();
        issued++;
        budget--;
      end
      // a few send or tick events, in the fin phase unless the budget ran out
      repeat ($urandom_range(1, 3)) begin
        put_event(($urandom_range(0, 1) == 0) ? ACT_SEND : ACT_TICK, 16'($urandom));
        issued++;
      end
    end
  endtask

  // Long result hold-off with the sender pushing, then a full drain mid-transfer.
  task automatic test_backpressure();
    int unsigned budget;
    wait_drained();
    write_reg(REG_TOTAL_SEGMENTS, 24'(snd_base) + 24'd60);
    write_reg(REG_INITIAL_THRESHOLD, 24'd8);
    write_reg(REG_TIMEOUT_TICKS, 24'd3);
    no_gaps     = 1'b1;
    holdoff_req = 1'b1;
    repeat (40) begin
      if (snd_base < cfg_total) send_flow_event();
      else put_event(ACT_TICK, 16'($urandom));
    end
    no_gaps = 1'b0;
    wait_drained();
    budget = 400;
    while (snd_base < cfg_total && budget > 0) begin
      send_flow_event();
      budget--;
    end
  endtask

  // Grow the window until it saturates, then time out from the full size.
  task automatic test_window_cap();
    int unsigned extra;
    wait_drained();
    write_reg(REG_TOTAL_SEGMENTS, 24'd65535);
    write_reg(REG_INITIAL_THRESHOLD, 24'd2047);
    extra = 0;
    // a full round at the cap is needed to see growth saturate
    while (extra < WIN_CAP + 64 && snd_base < 16'd65000) begin
      if (32'(cwnd) == WIN_CAP) extra++;
      put_event(ACT_ACK, snd_base + 16'($urandom_range(1, 3)));
    end
    wait_drained();
    write_reg(REG_TOTAL_SEGMENTS, 24'(snd_base) + 24'd1);
    write_reg(REG_TIMEOUT_TICKS, 24'd1);
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_TICK, 16'($urandom));
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_ACK, snd_base + 16'd1);
  endtask

  // Highest ack, FIN, fin-ack, then nothing moves any more.
  task automatic test_transfer_finish();
    wait_drained();
    write_reg(REG_TOTAL_SEGMENTS, 24'd65535);
    put_event(ACT_FIN_ACK, 16'($urandom));   // still data phase
    put_event(ACT_ACK, 16'hFFFF);
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_TICK, 16'($urandom));
    put_event(ACT_FIN_ACK, 16'($urandom));
    put_event(ACT_SEND, 16'($urandom));
    put_event(ACT_ACK, 16'hFFFF);
    put_event(ACT_TICK, 16'($urandom));
    put_event(ACT_FIN_ACK, 16'($urandom));
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    no_gaps        = 1'b0;
    holdoff_req    = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_SEND;
    ack_number_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_TOTAL_SEGMENTS;
    cfg_data_i   <= '0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_after_reset();
    test_register_extremes();
    test_random_transfers();
    test_backpressure();
    test_window_cap();
    test_transfer_finish();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cws_pkg.sv
rtl/cws_cfg.sv
rtl/cws_engine.sv
rtl/congestion_window_sender.sv
dv/congestion_window_sender_test.sv
